// File: src/bmp_pkg.sv
// shared types and constants for the bmp to rgb565 stream decoder
`default_nettype none
package bmp_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PIXELS = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  // result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // register indexes
  localparam logic [0:0] REG_MAX_DIM = 1'd0;

  localparam logic [9:0] MAX_DIM_RESET = 10'd600;
  localparam logic [5:0] HEADER_LAST   = 6'd53;
  localparam logic [31:0] HEADER_LEN   = 32'd54;

  // classified request passed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] row;
    logic [9:0] col;
    logic [9:0] width;
    logic [9:0] height;
    logic [15:0] color;
    logic        last;
  } job_t;

  // finished result
  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] addr;
    logic [15:0] color;
    logic [9:0]  width;
    logic [9:0]  height;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// File: src/bmp_front.sv
// byte parser: header capture, verdict, skip and pixel assembly
`default_nettype none
module bmp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           file_start_i,
  input  wire logic [9:0]     max_dim_i,
  output logic                job_valid_o,
  output bmp_pkg::job_t       job_o
);

  bmp_pkg::phase_e phase_q, phase_d;
  logic [5:0]  hidx_q, hidx_d;
  logic [63:0] kept_q, kept_d;
  logic [31:0] offs_q, offs_d;
  logic [31:0] skip_q, skip_d;
  logic [9:0]  wid_q, wid_d, row_q, row_d, col_q, col_d;
  logic [11:0] rb_q, rb_d;
  logic [1:0]  k_q, k_d;
  logic [15:0] bg_q, bg_d;
  logic        bad_q, bad_d;

  logic [11:0] pix_bytes, row_len;
  logic [31:0] w_raw, h_raw, h_mag;
  logic        rej;
  bmp_pkg::phase_e ph;

  assign pix_bytes = {2'b00, wid_q} * 12'd3;
  assign row_len   = (pix_bytes + 12'd3) & ~12'd3;

  // header capture and pixel walk
  always_comb begin
    phase_d = phase_q; hidx_d = hidx_q; kept_d = kept_q; offs_d = offs_q;
    skip_d = skip_q; wid_d = wid_q; row_d = row_q; col_d = col_q;
    rb_d = rb_q; k_d = k_q; bg_d = bg_q; bad_d = bad_q;
    job_valid_o = 1'b0;
    job_o = '0;
    w_raw = 32'd0; h_raw = 32'd0; h_mag = 32'd0; rej = 1'b0;
    ph = phase_q;
    if (valid_i) begin
      if (file_start_i) begin
        ph = bmp_pkg::PH_HEADER; hidx_d = '0; kept_d = '0; offs_d = '0;
        bad_d = 1'b0;
      end
      unique case (ph)
        bmp_pkg::PH_HEADER: begin
          phase_d = bmp_pkg::PH_HEADER;
          if (file_start_i) begin
            hidx_d = 6'd0;
          end
          if (hidx_d == 6'd0 && data_byte_i != 8'h42) bad_d = 1'b1;
          if (hidx_d == 6'd1 && data_byte_i != 8'h4D) bad_d = 1'b1;
          if (hidx_d == 6'd28 && data_byte_i != 8'd24) bad_d = 1'b1;
          if (hidx_d == 6'd29 && data_byte_i != 8'd0) bad_d = 1'b1;
          if (hidx_d >= 6'd10 && hidx_d <= 6'd13)
            offs_d[8*(hidx_d-6'd10) +: 8] = data_byte_i;
          if (hidx_d >= 6'd18 && hidx_d <= 6'd25)
            kept_d[8*(hidx_d-6'd18) +: 8] = data_byte_i;
          if (hidx_d >= bmp_pkg::HEADER_LAST) begin
            w_raw = kept_d[31:0];
            h_raw = kept_d[63:32];
            h_mag = h_raw[31] ? (32'd0 - h_raw) : h_raw;
            rej = bad_d || w_raw[31] || w_raw == 32'd0 || h_raw == 32'd0 ||
                  w_raw > {22'd0, max_dim_i} || h_mag > {22'd0, max_dim_i} ||
                  offs_d < bmp_pkg::HEADER_LEN;
            job_valid_o = 1'b1;
            if (rej) begin
              phase_d = bmp_pkg::PH_DONE;
              job_o.kind = bmp_pkg::KIND_REJECT;
            end else begin
              wid_d = w_raw[9:0];
              row_d = h_mag[9:0] - 10'd1;
              col_d = '0; rb_d = '0; k_d = '0;
              skip_d = offs_d - bmp_pkg::HEADER_LEN;
              phase_d = (skip_d != 32'd0) ? bmp_pkg::PH_SKIP : bmp_pkg::PH_PIXELS;
              job_o.kind = bmp_pkg::KIND_ACCEPT;
              job_o.width = w_raw[9:0];
              job_o.height = h_mag[9:0];
            end
          end else begin
            hidx_d = hidx_d + 6'd1;
          end
        end
        bmp_pkg::PH_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == 32'd0) phase_d = bmp_pkg::PH_PIXELS;
        end
        bmp_pkg::PH_PIXELS: begin
          if (rb_q < pix_bytes) begin
            if (k_q == 2'd0) bg_d[7:0] = data_byte_i;
            else if (k_q == 2'd1) bg_d[15:8] = data_byte_i;
            else begin
              job_valid_o = 1'b1;
              job_o.kind = bmp_pkg::KIND_PIXEL;
              job_o.row = row_q;
              job_o.col = col_q;
              job_o.color = {data_byte_i[7:3], bg_q[15:10], bg_q[7:3]};
              job_o.last = (row_q == 10'd0) && (col_q + 10'd1 == wid_q);
              col_d = col_q + 10'd1;
            end
            k_d = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
          end
          rb_d = rb_q + 12'd1;
          if (job_o.last) begin
            phase_d = bmp_pkg::PH_DONE;
          end else if (rb_d >= row_len) begin
            rb_d = '0; col_d = '0; k_d = '0;
            if (row_q == 10'd0) phase_d = bmp_pkg::PH_DONE;
            else row_d = row_q - 10'd1;
          end
        end
        default: phase_d = ph;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bmp_pkg::PH_IDLE;
      hidx_q <= '0; kept_q <= '0; offs_q <= '0; skip_q <= '0;
      wid_q <= '0; row_q <= '0; col_q <= '0;
      rb_q <= '0; k_q <= '0; bg_q <= '0; bad_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hidx_q <= hidx_d; kept_q <= kept_d; offs_q <= offs_d; skip_q <= skip_d;
      wid_q <= wid_d; row_q <= row_d; col_q <= col_d;
      rb_q <= rb_d; k_q <= k_d; bg_q <= bg_d; bad_q <= bad_d;
    end
  end

endmodule
`default_nettype wire

// File: src/bmp_back.sv
// result builder: address multiply-add, one register stage
`default_nettype none
module bmp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  bmp_pkg::job_t       job_i,
  output logic                job_ready_o,
  input  wire logic [9:0]     width_i,
  output logic                res_valid_o,
  output bmp_pkg::res_t       res_o,
  input  wire logic           res_ready_i
);

  logic          v_q;
  bmp_pkg::res_t r_q;
  logic [19:0]   addr;

  assign addr = job_i.row * width_i + {10'd0, job_i.col};
  assign job_ready_o = !v_q || res_ready_i;
  assign res_valid_o = v_q;
  assign res_o = r_q;

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (job_ready_o) begin
      v_q <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) begin
      r_q.kind <= job_i.kind;
      r_q.addr <= (job_i.kind == bmp_pkg::KIND_PIXEL) ? addr : 20'd0;
      r_q.color <= job_i.color;
      r_q.width <= job_i.width;
      r_q.height <= job_i.height;
      r_q.last <= job_i.last;
    end
  end

endmodule
`default_nettype wire

// File: src/bmp_fifo.sv
// short request queue between parser and result builder
`default_nettype none
module bmp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  bmp_pkg::job_t       data_i,
  output logic                full_o,
  output logic                valid_o,
  output bmp_pkg::job_t       data_o,
  input  wire logic           pop_i
);

  bmp_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i && valid_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i && valid_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

// File: src/bmp24_stream_to_rgb565_top.sv
// top level: bmp byte stream to rgb565 pixel requests
// a result passes the request queue and then the output register before it shows on the outputs
// throughput: one byte per cycle while the queue is not full, set by the parser
// the output register and a two-entry queue decouple parser and consumer
// reset clears all control state and sets max_dimension to 600
`default_nettype none
module bmp24_stream_to_rgb565_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        file_start_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [19:0]      pixel_address_o,
  output logic [15:0]      pixel_color_o,
  output logic [9:0]       image_width_o,
  output logic [9:0]       image_height_o,
  output logic             last_pixel_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [9:0]    max_dim_q;
  logic          jv, q_full, q_valid, b_ready, r_valid, acc;
  bmp_pkg::job_t job, q_job;
  bmp_pkg::res_t res;
  logic [9:0]    wid_q;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dim_q <= bmp_pkg::MAX_DIM_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == {bmp_pkg::REG_MAX_DIM, 1'b0}) begin
      max_dim_q <= pwdata[9:0];
    end
  end
  assign prdata = (paddr == {bmp_pkg::REG_MAX_DIM, 1'b0}) ? {22'd0, max_dim_q} : 32'd0;

  assign full = q_full;
  assign acc = push && !q_full;

  bmp_front u_front (
    .clk_i, .rst_ni, .valid_i(acc), .data_byte_i, .file_start_i,
    .max_dim_i(max_dim_q), .job_valid_o(jv), .job_o(job)
  );

  // width travels with pixel requests through the queue via a shadow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wid_q <= '0;
    else if (jv && job.kind == bmp_pkg::KIND_ACCEPT) wid_q <= job.width;
  end

  bmp_pkg::job_t job_w;
  always_comb begin
    job_w = job;
    if (job.kind == bmp_pkg::KIND_PIXEL) job_w.width = wid_q;
  end

  bmp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(jv), .data_i(job_w), .full_o(q_full),
    .valid_o(q_valid), .data_o(q_job), .pop_i(b_ready)
  );

  bmp_pkg::job_t q_job_c;
  always_comb begin
    q_job_c = q_job;
    if (q_job.kind == bmp_pkg::KIND_PIXEL) q_job_c.width = '0;
  end

  bmp_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_i(q_job_c), .job_ready_o(b_ready),
    .width_i(q_job.width), .res_valid_o(r_valid), .res_o(res), .res_ready_i(pop)
  );

  assign empty = !r_valid;
  assign kind_o = res.kind;
  assign pixel_address_o = res.addr;
  assign pixel_color_o = res.color;
  assign image_width_o = res.width;
  assign image_height_o = res.height;
  assign last_pixel_o = res.last;

  // a queue overflow would lose a request
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(jv && q_full))
    else $error("request queue overflow");
  // a held result stays put while not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_address_o) && $stable(kind_o)))
    else $error("result changed while waiting");
  // only pixel results carry last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_pixel_o) |-> kind_o == bmp_pkg::KIND_PIXEL)
    else $error("last on non-pixel result");

endmodule
`default_nettype wire

// File: bench/bmp24_checker.sv
// checker: watches byte and result channels, predicts rgb565 results, compares
`timescale 1ns / 100ps
`default_nettype none
module bmp24_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        file_start_i,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [1:0]  kind_o,
  input  wire logic [19:0] pixel_address_o,
  input  wire logic [15:0] pixel_color_o,
  input  wire logic [9:0]  image_width_o,
  input  wire logic [9:0]  image_height_o,
  input  wire logic        last_pixel_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fail_count,
  output int               pending_count
);

  // decoder copy of the block state
  bmp_pkg::phase_e ph;
  logic [5:0]  hdr_idx;
  logic [63:0] size_raw;
  logic [31:0] offs;
  logic [31:0] skip_left;
  logic [9:0]  wid, hgt, row, col, lim;
  logic [11:0] row_byte;
  logic [15:0] bg_hold;
  logic        hdr_bad;

  bmp_pkg::res_t pixel_q[$];

  // predict the result of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic st);
    bmp_pkg::res_t r;
    logic [31:0] w, h, hmag, pix_bytes, row_len, rb;
    logic bad;
    r = '0;
    if (st) begin
      ph = bmp_pkg::PH_HEADER; hdr_idx = 0; size_raw = 0; offs = 0; hdr_bad = 0;
    end
    case (ph)
      bmp_pkg::PH_HEADER: begin
        if (hdr_idx == 0 && b != 8'h42) hdr_bad = 1;
        if (hdr_idx == 1 && b != 8'h4D) hdr_bad = 1;
        if (hdr_idx == 28 && b != 8'd24) hdr_bad = 1;
        if (hdr_idx == 29 && b != 8'd0) hdr_bad = 1;
        if (hdr_idx >= 10 && hdr_idx <= 13) offs |= 32'(b) << (8 * (hdr_idx - 10));
        if (hdr_idx >= 18 && hdr_idx <= 25)
          size_raw |= 64'(b) << (8 * (hdr_idx - 18));
        if (hdr_idx >= bmp_pkg::HEADER_LAST) begin
          w = size_raw[31:0];
          h = size_raw[63:32];
          hmag = h[31] ? -h : h;
          bad = hdr_bad || w[31] || w == 0 || h == 0 || w > lim || hmag > lim
                || offs < bmp_pkg::HEADER_LEN;
          if (bad) begin
            ph = bmp_pkg::PH_DONE;
            r.kind = bmp_pkg::KIND_REJECT;
          end else begin
            wid = w[9:0]; hgt = hmag[9:0]; row = hgt - 1; col = 0; row_byte = 0;
            skip_left = offs - bmp_pkg::HEADER_LEN;
            ph = (skip_left != 0) ? bmp_pkg::PH_SKIP : bmp_pkg::PH_PIXELS;
            r.kind = bmp_pkg::KIND_ACCEPT; r.width = wid; r.height = hgt;
          end
          pixel_q.push_back(r);
        end else hdr_idx = hdr_idx + 1;
      end
      bmp_pkg::PH_SKIP: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) ph = bmp_pkg::PH_PIXELS;
      end
      bmp_pkg::PH_PIXELS: begin
        pix_bytes = 3 * wid;
        row_len = (pix_bytes + 3) & ~32'd3;
        rb = row_byte;
        if (rb < pix_bytes) begin
          case (rb % 3)
            0: bg_hold[7:0] = b;
            1: bg_hold[15:8] = b;
            default: begin
              r.kind = bmp_pkg::KIND_PIXEL;
              r.color = {b[7:3], bg_hold[15:10], bg_hold[7:3]};
              r.addr = {10'd0, row} * {10'd0, wid} + {10'd0, col};
              r.last = (row == 0 && 32'(col) + 1 == 32'(wid));
              pixel_q.push_back(r);
              if (r.last) begin
                ph = bmp_pkg::PH_DONE;
                return;
              end
              col = col + 1;
            end
          endcase
        end
        rb = rb + 1;
        if (rb >= row_len) begin
          rb = 0; col = 0;
          if (row == 0) ph = bmp_pkg::PH_DONE;
          else row = row - 1;
        end
        row_byte = rb[11:0];
      end
      default: ;
    endcase
  endtask

  // compare one field
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // watch the channels
  always @(posedge clk_i or negedge rst_ni) begin
    bmp_pkg::res_t e;
    if (!rst_ni) begin
      ph = bmp_pkg::PH_IDLE; hdr_idx = 0; size_raw = 0; offs = 0; skip_left = 0;
      wid = 0; hgt = 0; row = 0; col = 0; row_byte = 0; bg_hold = 0;
      hdr_bad = 0; lim = bmp_pkg::MAX_DIM_RESET; fail_count = 0;
      pixel_q.delete();
      pending_count = 0;
    end else begin
      if (pop && !empty) begin
        if (pixel_q.size() == 0) begin
          $error("result with nothing expected: kind %0d", kind_o);
          fail_count++;
        end else begin
          e = pixel_q.pop_front();
          check_field("kind", e.kind, kind_o);
          check_field("pixel_address", e.addr, pixel_address_o);
          check_field("pixel_color", e.color, pixel_color_o);
          check_field("image_width", e.width, image_width_o);
          check_field("image_height", e.height, image_height_o);
          check_field("last_pixel", e.last, last_pixel_o);
        end
      end
      if (psel && penable && pwrite && paddr == {bmp_pkg::REG_MAX_DIM, 1'b0})
        lim = pwdata[9:0];
      if (push && !full) decode_byte(data_byte_i, file_start_i);
      pending_count = pixel_q.size();
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_bmp24_stream_to_rgb565_top.sv
// testbench top: byte stream stimulus, config writes and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_bmp24_stream_to_rgb565_top;

  localparam int IDLE_LIMIT = 20000;

  logic        clk_i, rst_ni, push, pop, file_start_i;
  logic [7:0]  data_byte_i;
  logic        full, empty, last_pixel_o, pready;
  logic [1:0]  kind_o;
  logic [19:0] pixel_address_o;
  logic [15:0] pixel_color_o;
  logic [9:0]  image_width_o, image_height_o;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending_count;
  int          idle_cycles;
  int          bytes_sent;
  logic [7:0]  file_buf[$];
  logic        busy_gaps;

  bmp24_stream_to_rgb565_top u_top (.*);
  bmp24_checker u_chk (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // gap length: mostly short, sometimes long
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // result side stalls
  initial begin
    int g;
    pop = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop = 1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      g = busy_gaps ? gap_len() : 0;
      if (g > 0) begin
        @(negedge clk_i);
        pop = 0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one register write, setup then access
  task automatic write_max_dim(input logic [9:0] v);
    @(negedge clk_i);
    psel = 1; pwrite = 1; paddr = {bmp_pkg::REG_MAX_DIM, 1'b0};
    pwdata = {$urandom} & ~32'h3FF | {22'd0, v};
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // send one byte as a request
  task automatic send_byte(input logic [7:0] b, input logic st);
    int g;
    g = busy_gaps ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk_i);
      push = 0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push = 1; data_byte_i = b; file_start_i = st;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  // stream the buffered file
  task automatic send_file();
    foreach (file_buf[i]) send_byte(file_buf[i], i == 0);
  endtask

  // build a file: a header with random junk in unused bytes, then random payload
  task automatic build_file(input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] offs, input int broken, input int trunc);
    int n, rowlen, rows;
    file_buf.delete();
    for (int i = 0; i < 54; i++) file_buf.push_back(8'($urandom));
    file_buf[0] = 8'h42; file_buf[1] = 8'h4D;
    file_buf[28] = 8'd24; file_buf[29] = 8'd0;
    for (int k = 0; k < 4; k++) begin
      file_buf[10 + k] = offs[8*k +: 8];
      file_buf[18 + k] = w[8*k +: 8];
      file_buf[22 + k] = h[8*k +: 8];
    end
    case (broken)
      1: file_buf[0] = $urandom_range(0, 1) ? 8'hBD : 8'h43;
      2: file_buf[1] = $urandom_range(0, 1) ? 8'hB2 : 8'h4C;
      3: file_buf[28] = $urandom_range(0, 1) ? 8'd32 : 8'd8;
      4: file_buf[29] = 8'h80;
      default: ;
    endcase
    rowlen = (3 * (w[9:0]) + 3) & ~3;
    rows = h[31] ? -h : h;
    if (rows > 16) rows = 16;
    n = (offs > 54 && offs < 200 ? offs - 54 : 0) + rowlen * rows[9:0] + 2;
    if (trunc > 0 && trunc < n) n = trunc;
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom));
  endtask

  // drain: wait for all results, then the block latency
  task automatic drain();
    @(negedge clk_i);
    push = 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int w, h, kind;
    push = 0; data_byte_i = 0; file_start_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    idle_cycles = 0; bytes_sent = 0; busy_gaps = 1;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: bytes before any start are ignored
    send_byte(8'hFF, 0);
    send_byte(8'h00, 0);
    // smallest image, all-ones then all-zero pixel bytes
    build_file(1, 1, 54, 0, 0);
    file_buf[54] = 8'hFF; file_buf[55] = 8'hFF; file_buf[56] = 8'hFF;
    send_file();
    build_file(2, 2, 54, 0, 0);
    for (int i = 54; i < file_buf.size(); i++) file_buf[i] = 8'd0;
    send_file();
    // negative height, skip area, each malformed header
    build_file(3, -3, 60, 0, 0); send_file();
    for (int b = 1; b <= 4; b++) begin build_file(2, 2, 54, b, 0); send_file(); end
    build_file(0, 2, 54, 0, 0); send_file();
    build_file(32'h8000_0002, 2, 54, 0, 0); send_file();
    build_file(2, 0, 54, 0, 0); send_file();
    build_file(2, 32'h8000_0000, 54, 0, 0); send_file();
    build_file(601, 1, 54, 0, 10); send_file();
    build_file(1, 601, 54, 0, 10); send_file();
    build_file(600, 1, 54, 0, 10); send_file();
    build_file(2, 2, 53, 0, 0); send_file();
    build_file(2, 2, 32'hFFFF_FF00, 0, 10); send_file();
    // truncated, restarted mid-pixels
    build_file(4, 4, 54, 0, 20); send_file();
    // a further byte is taken as pixel data of the truncated file
    send_byte(8'h42, 0);

    // pause until everything is through, then exercise the limits
    drain();
    write_max_dim(10'd1);
    build_file(1, 1, 54, 0, 0); send_file();
    build_file(2, 1, 54, 0, 0); send_file();
    drain();
    write_max_dim(10'd1023);
    build_file(1023, 1, 54, 0, 9); send_file();
    build_file(1, 1023, 54, 0, 10); send_file();
    build_file(1024, 1, 54, 0, 10); send_file();
    drain();
    write_max_dim(10'd600);

    // random files, mostly well formed small images
    while (bytes_sent < 1550) begin
      if ($urandom_range(0, 9) == 0) begin
        drain();
        write_max_dim(10'($urandom_range(0, 3) == 0 ? $urandom_range(1, 1023)
                                                     : $urandom_range(4, 12)));
      end
      busy_gaps = ($urandom_range(0, 4) != 0);
      w = $urandom_range(1, 7);
      h = $urandom_range(1, 5);
      if ($urandom_range(0, 1)) h = -h;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise
        for (int i = 0; i < $urandom_range(1, 20); i++)
          send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end else begin
        build_file(w, h, 54 + ($urandom_range(0, 2) == 0 ? $urandom_range(1, 12) : 0),
                   kind == 1 ? $urandom_range(1, 4) : 0,
                   kind == 2 ? $urandom_range(1, 70) : 0);
        send_file();
      end
    end

    drain();
    busy_gaps = 1;
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
src/bmp_pkg.sv
src/bmp_front.sv
src/bmp_back.sv
src/bmp_fifo.sv
src/bmp24_stream_to_rgb565_top.sv
bench/bmp24_checker.sv
bench/tb_bmp24_stream_to_rgb565_top.sv
